// ===== src/peae_pkg.sv =====
// Package of the packed element array engine.
// Holds the action, status and controller state codes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package peae_pkg;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_SEARCH = 3'd4,
    ACT_RUN    = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_NONE   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SP_LO  = 2'd0,
    SP_HI  = 2'd1,
    SP_EXP = 2'd2,
    SP_BIN = 2'd3
  } phase_e;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b1 << 0,
    S_DECODE = 18'b1 << 1,
    S_GMUL   = 18'b1 << 2,
    S_GRD0   = 18'b1 << 3,
    S_GRD1   = 18'b1 << 4,
    S_GRD2   = 18'b1 << 5,
    S_SNEXT  = 18'b1 << 6,
    S_IRD0   = 18'b1 << 7,
    S_IRD1   = 18'b1 << 8,
    S_ISH    = 18'b1 << 9,
    S_ILAST  = 18'b1 << 10,
    S_SRD0   = 18'b1 << 11,
    S_SWR0   = 18'b1 << 12,
    S_SWR1   = 18'b1 << 13,
    S_DRD0   = 18'b1 << 14,
    S_DRD1   = 18'b1 << 15,
    S_DSH    = 18'b1 << 16,
    S_DLAST  = 18'b1 << 17
  } state_e;

endpackage
`default_nettype wire

// ===== src/packed_element_array_engine.sv =====
// Top level of the packed element array engine: controller and word memory.
// Depends on peae_pkg for action, status and state codes.
`timescale 1ns / 1ps
`default_nettype none
// Elements of 1 to 64 bits lie packed in a memory of STORE_WORDS 64-bit words
// with one read and one write port. A read fetches the element's word and the
// next one; a write rewrites the element's word, and the next one too when the
// element straddles two words. An insert shifts each word from the new end of
// the array down to the element's word, then writes the element in; a delete
// shifts the words from the element's word up to the end of the array. A search
// probes one element at a time, and a read run reads its elements in turn.
// A result is shown for one cycle only and must be taken then; busy_o stays
// high until the last result is out.
module packed_element_array_engine
  import peae_pkg::*;
#(
  parameter int STORE_WORDS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [12:0] index_i,
  input  wire logic [12:0] end_index_i,
  input  wire logic [6:0]  run_length_i,
  input  wire logic [63:0] value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_element_width_i,
  output logic             result_valid_o,
  output logic [63:0]      element_o,
  output logic [13:0]      position_o,
  output logic [13:0]      count_now_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [21:0] StoreBits = 22'(STORE_WORDS * 64);

  logic [63:0] mem_q [STORE_WORDS];
  logic [63:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  state_e  state_q;
  action_e act_q;
  phase_e  sph_q;
  logic [13:0] cnt_q;
  logic [6:0]  wd_q;
  logic [12:0] idx_q, endi_q, k_q;
  logic [6:0]  len_q, run_n_q;
  logic [63:0] val_q, w0_q, hi_q, lo_q;
  logic [19:0] pos_q;
  logic [21:0] prod1_q, prod2_q;
  logic [AW-1:0] wq_q, top_q;
  logic [14:0] slo_q, sd_q;
  logic [13:0] se_q;

  logic          res_valid_q, last_q;
  logic [63:0]   elem_q;
  logic [13:0]   rpos_q, rcnt_q;
  status_e       status_q;

  logic [5:0]    off;
  logic [AW-1:0] q;
  logic [63:0]   wmask, lmask, elem, set_lo, set_hi;
  logic [127:0]  mval, mmask;
  logic          strad, ge, full, set_fin, del_fin;
  logic [14:0]   lo_d;
  logic [13:0]   emin;
  logic [6:0]    wd_d;

  function automatic logic [63:0] f_ins(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic first, input logic [6:0] wd,
                                        input logic [63:0] lm);
    logic [127:0] s;
    s = {hi, lo} << wd;
    return first ? ((hi & lm) | (s[127:64] & ~lm)) : s[127:64];
  endfunction

  function automatic logic [63:0] f_del(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic first, input logic [6:0] wd,
                                        input logic [63:0] lm);
    logic [127:0] s;
    s = {hi, lo} >> wd;
    return first ? ((lo & lm) | (s[63:0] & ~lm)) : s[63:0];
  endfunction

  assign off    = pos_q[5:0];
  assign q      = pos_q[AW+5:6];
  assign wmask  = ~({64{1'b1}} << wd_q);
  assign lmask  = ~({64{1'b1}} << off);
  assign strad  = (8'(off) + 8'(wd_q)) > 8'd64;
  assign mval   = {64'd0, val_q & wmask} << off;
  assign mmask  = {64'd0, wmask} << off;
  assign set_lo = (rdata_q & ~mmask[63:0]) | mval[63:0];
  assign set_hi = (rdata_q & ~mmask[127:64]) | mval[127:64];
  assign elem   = 64'({rdata_q, w0_q} >> off) & wmask;
  assign ge     = elem >= val_q;
  assign full   = cnt_q[13] || (prod1_q > StoreBits) || (!cnt_q[0] && (prod2_q > StoreBits));
  assign lo_d   = slo_q + sd_q;
  assign emin   = (lo_d < 15'(endi_q)) ? 14'(lo_d) : 14'(endi_q);
  assign set_fin = (state_q == S_SWR0 && !strad) || state_q == S_SWR1;
  assign del_fin = (state_q == S_DRD1 && wq_q == top_q) || state_q == S_DLAST;
  assign wd_d   = (cfg_element_width_i == 7'd0) ? 7'd1 :
                  (cfg_element_width_i > 7'd64) ? 7'd64 : cfg_element_width_i;

  assign busy_o         = state_q != S_IDLE;
  assign cfg_ready_o    = state_q == S_IDLE;
  assign result_valid_o = res_valid_q;
  assign element_o      = elem_q;
  assign position_o     = rpos_q;
  assign count_now_o    = rcnt_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wq_q;
    mem_raddr = q;
    mem_wdata = 64'd0;
    case (state_q)
      S_GRD0, S_SRD0: begin
        mem_re = 1'b1;
      end
      S_GRD1: begin
        mem_re    = 1'b1;
        mem_raddr = q + AW'(1);
      end
      S_IRD0: begin
        mem_re    = 1'b1;
        mem_raddr = top_q;
      end
      S_IRD1: begin
        mem_we    = wq_q == q;
        mem_wdata = f_ins(rdata_q, rdata_q, 1'b1, wd_q, lmask);
        mem_re    = wq_q != q;
        mem_raddr = wq_q - AW'(1);
      end
      S_ISH: begin
        mem_we    = 1'b1;
        mem_waddr = wq_q + AW'(1);
        mem_wdata = f_ins(hi_q, rdata_q, 1'b0, wd_q, lmask);
        mem_re    = wq_q != q;
        mem_raddr = wq_q - AW'(1);
      end
      S_ILAST: begin
        mem_we    = 1'b1;
        mem_waddr = wq_q + AW'(1);
        mem_wdata = f_ins(hi_q, hi_q, 1'b1, wd_q, lmask);
      end
      S_SWR0: begin
        mem_we    = 1'b1;
        mem_waddr = q;
        mem_wdata = set_lo;
        mem_re    = strad;
        mem_raddr = q + AW'(1);
      end
      S_SWR1: begin
        mem_we    = 1'b1;
        mem_waddr = q + AW'(1);
        mem_wdata = set_hi;
      end
      S_DRD0: begin
        mem_re = 1'b1;
      end
      S_DRD1: begin
        mem_we    = wq_q == top_q;
        mem_wdata = f_del(64'd0, rdata_q, 1'b1, wd_q, lmask);
        mem_re    = wq_q != top_q;
        mem_raddr = wq_q + AW'(1);
      end
      S_DSH: begin
        mem_we    = 1'b1;
        mem_wdata = f_del(rdata_q, lo_q, wq_q == q, wd_q, lmask);
        mem_re    = (wq_q + AW'(1)) != top_q;
        mem_raddr = wq_q + AW'(2);
      end
      S_DLAST: begin
        mem_we    = 1'b1;
        mem_wdata = f_del(64'd0, lo_q, wq_q == q, wd_q, lmask);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 14'd0;
      wd_q        <= 7'd8;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      elem_q      <= 64'd0;
      rpos_q      <= 14'd0;
      rcnt_q      <= cnt_q;
      status_q    <= ST_OK;
      last_q      <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            wd_q  <= wd_d;
            cnt_q <= 14'd0;
          end
          if (start_i) begin
            act_q   <= action_e'(action_i);
            idx_q   <= index_i;
            endi_q  <= end_index_i;
            val_q   <= value_i;
            len_q   <= (run_length_i == 7'd0) ? 7'd1 :
                       (run_length_i > 7'd64) ? 7'd64 : run_length_i;
            prod1_q <= 22'(cnt_q + 14'd1) * 22'(wd_q);
            prod2_q <= 22'(cnt_q + 14'd2) * 22'(wd_q);
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          pos_q   <= 20'(idx_q) * 20'(wd_q);
          k_q     <= idx_q;
          run_n_q <= 7'd0;
          slo_q   <= 15'(idx_q);
          sph_q   <= SP_LO;
          state_q <= S_IDLE;
          case (act_q)
            ACT_READ: begin
              if (14'(idx_q) >= cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else begin
                state_q <= S_GMUL;
              end
            end
            ACT_WRITE: begin
              if (14'(idx_q) >= cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else begin
                state_q <= S_SRD0;
              end
            end
            ACT_INSERT: begin
              top_q <= AW'((prod1_q - 22'd1) >> 6);
              if (14'(idx_q) > cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else if (full) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_FULL;
              end else begin
                state_q <= S_IRD0;
              end
            end
            ACT_DELETE: begin
              top_q <= AW'((prod1_q - 22'(wd_q) - 22'd1) >> 6);
              if (14'(idx_q) >= cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else begin
                state_q <= S_DRD0;
              end
            end
            ACT_SEARCH: begin
              if (idx_q > endi_q || 14'(endi_q) >= cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else begin
                state_q <= S_GMUL;
              end
            end
            ACT_RUN: begin
              if ((14'(idx_q) + 14'(len_q)) > cnt_q) begin
                res_valid_q <= 1'b1;
                status_q    <= ST_INDEX;
              end else begin
                state_q <= S_GMUL;
              end
            end
            ACT_CLEAR: begin
              cnt_q       <= 14'd0;
              rcnt_q      <= 14'd0;
              res_valid_q <= 1'b1;
            end
            default: begin
              res_valid_q <= 1'b1;
            end
          endcase
        end
        S_GMUL: begin
          pos_q   <= 20'(k_q) * 20'(wd_q);
          state_q <= S_GRD0;
        end
        S_GRD0: begin
          state_q <= S_GRD1;
        end
        S_GRD1: begin
          w0_q    <= rdata_q;
          state_q <= S_GRD2;
        end
        S_GRD2: begin
          state_q <= S_IDLE;
          case (act_q)
            ACT_RUN: begin
              res_valid_q <= 1'b1;
              elem_q      <= elem;
              last_q      <= (run_n_q + 7'd1) == len_q;
              run_n_q     <= run_n_q + 7'd1;
              k_q         <= k_q + 13'd1;
              if ((run_n_q + 7'd1) != len_q) begin
                state_q <= S_GMUL;
              end
            end
            ACT_SEARCH: begin
              state_q <= S_SNEXT;
              case (sph_q)
                SP_LO: begin
                  if (ge) begin
                    res_valid_q <= 1'b1;
                    rpos_q      <= 14'(idx_q);
                    state_q     <= S_IDLE;
                  end else begin
                    k_q     <= endi_q;
                    sph_q   <= SP_HI;
                    state_q <= S_GMUL;
                  end
                end
                SP_HI: begin
                  if (!ge) begin
                    res_valid_q <= 1'b1;
                    rpos_q      <= 14'(endi_q) + 14'd1;
                    state_q     <= S_IDLE;
                  end else begin
                    sd_q  <= 15'd1;
                    sph_q <= SP_EXP;
                  end
                end
                SP_EXP: begin
                  if (ge) begin
                    se_q  <= emin;
                    sph_q <= SP_BIN;
                  end else begin
                    slo_q <= lo_d;
                    sd_q  <= sd_q << 1;
                  end
                end
                default: begin
                  if (!ge) begin
                    slo_q <= 15'(k_q);
                  end else begin
                    se_q <= 14'(k_q);
                  end
                end
              endcase
            end
            default: begin
              res_valid_q <= 1'b1;
              elem_q      <= elem;
            end
          endcase
        end
        S_SNEXT: begin
          if (sph_q == SP_EXP) begin
            if (lo_d <= 15'(endi_q)) begin
              k_q     <= 13'(lo_d);
              state_q <= S_GMUL;
            end else begin
              se_q  <= emin;
              sph_q <= SP_BIN;
            end
          end else if ((slo_q + 15'd1) < 15'(se_q)) begin
            k_q     <= 13'((slo_q + 15'(se_q)) >> 1);
            state_q <= S_GMUL;
          end else begin
            res_valid_q <= 1'b1;
            rpos_q      <= se_q;
            state_q     <= S_IDLE;
          end
        end
        S_IRD0: begin
          wq_q    <= top_q;
          state_q <= S_IRD1;
        end
        S_IRD1: begin
          hi_q    <= rdata_q;
          wq_q    <= wq_q - AW'(1);
          state_q <= (wq_q == q) ? S_SRD0 : S_ISH;
        end
        S_ISH: begin
          hi_q    <= rdata_q;
          wq_q    <= wq_q - AW'(1);
          if (wq_q == q) begin
            state_q <= S_ILAST;
          end
        end
        S_ILAST: begin
          state_q <= S_SRD0;
        end
        S_SRD0: begin
          state_q <= S_SWR0;
        end
        S_SWR0: begin
          state_q <= S_SWR1;
        end
        S_DRD0: begin
          wq_q    <= q;
          state_q <= S_DRD1;
        end
        S_DRD1: begin
          lo_q    <= rdata_q;
          state_q <= S_DSH;
        end
        S_DSH: begin
          lo_q <= rdata_q;
          wq_q <= wq_q + AW'(1);
          if ((wq_q + AW'(1)) == top_q) begin
            state_q <= S_DLAST;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (set_fin) begin
        res_valid_q <= 1'b1;
        state_q     <= S_IDLE;
        if (act_q == ACT_INSERT) begin
          cnt_q  <= cnt_q + 14'd1;
          rcnt_q <= cnt_q + 14'd1;
        end
      end
      if (del_fin) begin
        res_valid_q <= 1'b1;
        state_q     <= S_IDLE;
        cnt_q       <= cnt_q - 14'd1;
        rcnt_q      <= cnt_q - 14'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/packed_element_array_engine_tb.sv =====
// Self-checking testbench of the packed element array engine.
// Depends on peae_pkg and packed_element_array_engine from the src folder.
`timescale 1ns / 1ps

module packed_element_array_engine_tb;
  import peae_pkg::*;

  localparam int NWORDS = 128;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [63:0] element;
    logic [13:0] position;
    logic [13:0] count_now;
    status_e     status;
    logic        last;
  } outcome_t;

  class array_scoreboard;
    logic [63:0] words[NWORDS];
    int unsigned count;
    logic [6:0]  width_reg;
    outcome_t    pending[$];
    int          errors;

    function new();
      count = 0;
      width_reg = 7'd8;
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned bits_per();
      if (width_reg == 0) return 1;
      if (width_reg > 64) return 64;
      return width_reg;
    endfunction

    function logic [63:0] wmask();
      int unsigned wd;
      wd = bits_per();
      return (wd >= 64) ? '1 : ((64'd1 << wd) - 64'd1);
    endfunction

    function int unsigned capacity();
      int unsigned c;
      c = (NWORDS * 64) / bits_per();
      c = c & ~1;
      return (c > 8192) ? 8192 : c;
    endfunction

    function logic [63:0] fetch(int unsigned k);
      int unsigned p, q, off, wd;
      logic [63:0] v;
      wd = bits_per();
      p = k * wd;
      q = p >> 6;
      off = p & 63;
      if (q >= NWORDS) return '0;
      v = words[q] >> off;
      if (off + wd > 64 && q + 1 < NWORDS) v = v | (words[q + 1] << (64 - off));
      return v & wmask();
    endfunction

    function void store(int unsigned k, logic [63:0] v);
      int unsigned p, q, off, wd;
      logic [63:0] m;
      wd = bits_per();
      m = wmask();
      p = k * wd;
      q = p >> 6;
      off = p & 63;
      if (q >= NWORDS) return;
      v = v & m;
      words[q] = (words[q] & ~(m << off)) | (v << off);
      if (off + wd > 64 && q + 1 < NWORDS)
        words[q + 1] = (words[q + 1] & ~(m >> (64 - off))) | (v >> (64 - off));
    endfunction

    function int unsigned successor(int unsigned lo, int unsigned hi, logic [63:0] key);
      int unsigned d, e, m;
      d = 1;
      if (fetch(lo) >= key) return lo;
      if (fetch(hi) < key) return hi + 1;
      while (lo + d <= hi) begin
        if (fetch(lo + d) >= key) break;
        lo = lo + d;
        d = d << 1;
      end
      e = (lo + d < hi) ? lo + d : hi;
      while (lo + 1 < e) begin
        m = (lo + e) >> 1;
        if (fetch(m) < key) lo = m;
        else e = m;
      end
      return e;
    endfunction

    function void push(logic [63:0] el, int unsigned pos, status_e st, logic lst);
      outcome_t o;
      o.element = el;
      o.position = pos[13:0];
      o.count_now = count[13:0];
      o.status = st;
      o.last = lst;
      pending.push_back(o);
    endfunction

    function void set_width(logic [6:0] w);
      width_reg = w;
      count = 0;
    endfunction

    function void note(action_e act, logic [12:0] idx, logic [12:0] endi,
                       logic [6:0] rlen, logic [63:0] val);
      int unsigned len;
      case (act)
        ACT_READ: begin
          if (idx >= count) push('0, 0, ST_INDEX, 1);
          else push(fetch(idx), 0, ST_OK, 1);
        end
        ACT_WRITE: begin
          if (idx >= count) push('0, 0, ST_INDEX, 1);
          else begin
            store(idx, val);
            push('0, 0, ST_OK, 1);
          end
        end
        ACT_INSERT: begin
          if (idx > count) push('0, 0, ST_INDEX, 1);
          else if (count >= capacity()) push('0, 0, ST_FULL, 1);
          else begin
            for (int unsigned k = count; k > idx; k--) store(k, fetch(k - 1));
            store(idx, val);
            count++;
            push('0, 0, ST_OK, 1);
          end
        end
        ACT_DELETE: begin
          if (idx >= count) push('0, 0, ST_INDEX, 1);
          else begin
            for (int unsigned k = idx; k + 1 < count; k++) store(k, fetch(k + 1));
            count--;
            push('0, 0, ST_OK, 1);
          end
        end
        ACT_SEARCH: begin
          if (idx > endi || endi >= count) push('0, 0, ST_INDEX, 1);
          else push('0, successor(idx, endi, val), ST_OK, 1);
        end
        ACT_RUN: begin
          len = rlen;
          if (len == 0) len = 1;
          if (len > 64) len = 64;
          if (idx + len > count) push('0, 0, ST_INDEX, 1);
          else for (int unsigned k = 0; k < len; k++)
            push(fetch(idx + k), 0, ST_OK, k + 1 == len);
        end
        ACT_CLEAR: begin
          count = 0;
          push('0, 0, ST_OK, 1);
        end
        default: push('0, 0, ST_OK, 1);
      endcase
    endfunction

    function void check(logic [63:0] el, logic [13:0] pos, logic [13:0] cnt,
                        logic [1:0] st, logic lst);
      outcome_t o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result element=%h status=%0d", $time, el, st);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (el !== o.element) begin
        $display("%0t: element expected %h actual %h", $time, o.element, el);
        errors++;
      end
      if (pos !== o.position) begin
        $display("%0t: position expected %0d actual %0d", $time, o.position, pos);
        errors++;
      end
      if (cnt !== o.count_now) begin
        $display("%0t: count expected %0d actual %0d", $time, o.count_now, cnt);
        errors++;
      end
      if (st !== o.status) begin
        $display("%0t: status expected %0d actual %0d", $time, o.status, st);
        errors++;
      end
      if (lst !== o.last) begin
        $display("%0t: last expected %b actual %b", $time, o.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  action_i = '0;
  logic [12:0] index_i = '0;
  logic [12:0] end_index_i = '0;
  logic [6:0]  run_length_i = '0;
  logic [63:0] value_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_element_width_i = '0;
  logic        result_valid_o;
  logic [63:0] element_o;
  logic [13:0] position_o;
  logic [13:0] count_now_o;
  logic [1:0]  status_o;
  logic        last_o;

  array_scoreboard sb;
  bit idling;
  int stall_cycles = 0;

  packed_element_array_engine #(.STORE_WORDS(NWORDS)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check(element_o, position_o, count_now_o, status_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || result_valid_o)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(action_e act, int unsigned idx, int unsigned endi,
                      int unsigned rlen, logic [63:0] val);
    if (idling && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    index_i <= idx[12:0];
    end_index_i <= endi[12:0];
    run_length_i <= rlen[6:0];
    value_i <= val;
    do @(posedge clk_i); while (busy_o);
    sb.note(act, idx[12:0], endi[12:0], rlen[6:0], val);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0 || busy_o);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_width(logic [6:0] w);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_element_width_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_width(w);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic sorted_block();
    logic [63:0] v;
    int n;
    int unsigned lo, hi;
    n = $urandom_range(4, 30);
    v = 64'($urandom_range(0, 3));
    send(ACT_CLEAR, 0, 0, 1, rand_value());
    for (int i = 0; i < n && sb.count < sb.capacity(); i++) begin
      send(ACT_INSERT, sb.count, 0, 1, v);
      v = v + 64'($urandom_range(0, 4));
    end
    repeat ($urandom_range(4, 12)) begin
      lo = $urandom_range(0, sb.count - 1);
      hi = $urandom_range(lo, sb.count - 1);
      send(ACT_SEARCH, lo, hi, 1, 64'($urandom_range(0, int'(v) + 2)));
    end
  endtask

  task automatic random_item();
    int unsigned r, c;
    bit bad;
    r = $urandom_range(0, 99);
    c = sb.count;
    bad = ($urandom_range(0, 9) == 0) || c == 0;
    if (r < 30)
      send(ACT_INSERT, bad ? $urandom_range(0, 8191) : $urandom_range(0, c), 0, 1,
           rand_value());
    else if (r < 45)
      send(ACT_DELETE, bad ? $urandom_range(0, 8191) : $urandom_range(0, c - 1), 0, 1, 0);
    else if (r < 58)
      send(ACT_READ, bad ? $urandom_range(0, 8191) : $urandom_range(0, c - 1), 0, 1, 0);
    else if (r < 70)
      send(ACT_WRITE, bad ? $urandom_range(0, 8191) : $urandom_range(0, c - 1), 0, 1,
           rand_value());
    else if (r < 82) begin
      if (bad) send(ACT_RUN, $urandom_range(0, 8191), 0, $urandom_range(0, 127), 0);
      else begin
        r = $urandom_range(1, (c > 64) ? 64 : c);
        send(ACT_RUN, $urandom_range(0, c - r), 0, r, 0);
      end
    end
    else if (r < 94) begin
      if (bad) send(ACT_SEARCH, $urandom_range(0, 8191), $urandom_range(0, 8191), 1,
                    rand_value());
      else begin
        r = $urandom_range(0, c - 1);
        send(ACT_SEARCH, r, $urandom_range(r, c - 1), 1, rand_value());
      end
    end
    else if (r < 97) send(ACT_CLEAR, 0, 0, 1, 0);
    else send(ACT_NONE, $urandom_range(0, 8191), $urandom_range(0, 8191), 1, rand_value());
  endtask

  initial begin
    logic [6:0] widths[7];
    sb = new();
    widths = '{7'd13, 7'd1, 7'd0, 7'd127, 7'd37, 7'd8, 7'd5};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling = 1;

    send(ACT_READ, 0, 0, 1, 0);
    send(ACT_INSERT, 8191, 0, 1, '1);
    send(ACT_INSERT, 0, 0, 1, '1);
    send(ACT_INSERT, 1, 0, 1, 64'h0);
    send(ACT_INSERT, 1, 0, 1, 64'h80);
    send(ACT_WRITE, 0, 0, 1, 64'h5A);
    send(ACT_WRITE, 8191, 0, 1, 64'h1);
    send(ACT_READ, 1, 0, 1, 0);
    send(ACT_RUN, 0, 0, 0, 0);
    send(ACT_RUN, 0, 0, 127, 0);
    send(ACT_RUN, 0, 0, 3, 0);
    send(ACT_SEARCH, 0, 2, 1, 64'h5B);
    send(ACT_SEARCH, 2, 1, 1, 0);
    send(ACT_SEARCH, 0, 8191, 1, 0);
    send(ACT_SEARCH, 1, 2, 1, '1);
    send(ACT_DELETE, 8191, 0, 1, 0);
    send(ACT_DELETE, 0, 0, 1, 0);
    send(ACT_NONE, 8191, 8191, 127, '1);
    send(ACT_CLEAR, 0, 0, 1, 0);
    send(ACT_READ, 0, 0, 1, 0);

    write_width(7'd64);
    for (int i = 0; i < 128; i++) send(ACT_INSERT, i, 0, 1, {$urandom, $urandom});
    send(ACT_INSERT, 8191, 0, 1, 0);
    send(ACT_INSERT, 0, 0, 1, 0);
    send(ACT_RUN, 64, 0, 64, 0);
    send(ACT_DELETE, 0, 0, 1, 0);

    foreach (widths[w]) begin
      write_width(widths[w]);
      idling = (w < 5);
      repeat (2) begin
        if ($urandom_range(0, 1) == 0) sorted_block();
        repeat ($urandom_range(4, 10)) random_item();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/peae_pkg.sv
src/packed_element_array_engine.sv
sim/packed_element_array_engine_tb.sv
